// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the frame parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with a synchronous active-low reset.
`define SCFP_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scfp assertion failed");

// Shorthand on the block clock and reset.
`define SCFP_ASSERT(lbl, prop) \
    `SCFP_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== hdl/scfp_pkg.sv =====
// ---------------------------------------------------------------------------
// scfp_pkg
// Types and constants shared by the serial command frame parser.
// ---------------------------------------------------------------------------
package scfp_pkg;

    // Register map: index is paddr[2]
    localparam int unsigned ADDR_W       = 3;
    localparam logic [0:0]  CFG_IDX_START = 1'b0;
    localparam logic [0:0]  CFG_IDX_END   = 1'b1;

    localparam logic [7:0] START_BYTE_RST = 8'd36;  // '$'
    localparam logic [7:0] END_BYTE_RST   = 8'd35;  // '#'

    // Frame characters
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_L    = 8'h4C;

    // Output codes
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    localparam logic [1:0] CMD_M = 2'd0;
    localparam logic [1:0] CMD_C = 2'd1;
    localparam logic [1:0] CMD_T = 2'd2;

    localparam logic [1:0] DIR_F = 2'd0;
    localparam logic [1:0] DIR_B = 2'd1;
    localparam logic [1:0] DIR_R = 2'd2;
    localparam logic [1:0] DIR_L = 2'd3;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } t_cfg;

    typedef struct packed {
        logic       frame_done;
        logic       frame_kind;
        logic [1:0] command_code;
        logic [1:0] move_direction;
        logic [6:0] move_speed;
        logic       parse_error;
    } t_result;

endpackage

// ===== hdl/scfp_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// scfp_cfg_regs
// APB register file holding the start and end delimiter bytes.
// ---------------------------------------------------------------------------
module scfp_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output scfp_pkg::t_cfg              o_cfg
);

    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= scfp_pkg::START_BYTE_RST;
            r_end_byte   <= scfp_pkg::END_BYTE_RST;
        end else if (wr_en) begin
            case (paddr[2])
                scfp_pkg::CFG_IDX_START: r_start_byte <= pwdata[7:0];
                scfp_pkg::CFG_IDX_END:   r_end_byte   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            scfp_pkg::CFG_IDX_START: prdata = {24'd0, r_start_byte};
            scfp_pkg::CFG_IDX_END:   prdata = {24'd0, r_end_byte};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg.start_byte = r_start_byte;
    assign o_cfg.end_byte   = r_end_byte;

endmodule

// ===== hdl/scfp_parser.sv =====
// ---------------------------------------------------------------------------
// scfp_parser
// Per-beat frame state machine with a registered result stage.
// ---------------------------------------------------------------------------
module scfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scfp_pkg::t_cfg    i_cfg,
    input  logic              i_rx_valid,
    input  logic [7:0]        i_rx_byte,
    output logic              o_rx_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output scfp_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_TYPE  = 3'd1,
        PH_VEL1  = 3'd2,
        PH_VEL2  = 3'd3,
        PH_END   = 3'd4
    } t_phase;

    t_phase            r_phase,  n_phase;
    logic              r_kind,   n_kind;
    logic [1:0]        r_cmd,    n_cmd;
    logic [1:0]        r_dir,    n_dir;
    logic [6:0]        r_speed,  n_speed;
    logic              r_res_valid;
    scfp_pkg::t_result r_res,    n_res;

    logic       accept;
    logic       done;
    logic       err;
    logic [6:0] digit;
    logic       is_digit;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign accept     = i_rx_valid && o_rx_ready;

    // ASCII digits sit at 0x30..0x39, so the low nibble is the value
    assign digit    = {3'b000, i_rx_byte[3:0]};
    assign is_digit = i_rx_byte inside {[scfp_pkg::CH_ZERO:scfp_pkg::CH_NINE]};

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_cmd   = r_cmd;
        n_dir   = r_dir;
        n_speed = r_speed;
        done    = 1'b0;
        err     = 1'b0;

        case (r_phase)
            PH_TYPE: begin
                n_phase = PH_END;
                case (i_rx_byte)
                    scfp_pkg::CH_M: begin
                        n_kind = scfp_pkg::KIND_CMD;
                        n_cmd  = scfp_pkg::CMD_M;
                    end
                    scfp_pkg::CH_C: begin
                        n_kind = scfp_pkg::KIND_CMD;
                        n_cmd  = scfp_pkg::CMD_C;
                    end
                    scfp_pkg::CH_T: begin
                        n_kind = scfp_pkg::KIND_CMD;
                        n_cmd  = scfp_pkg::CMD_T;
                    end
                    scfp_pkg::CH_F: begin
                        n_kind  = scfp_pkg::KIND_MOVE;
                        n_dir   = scfp_pkg::DIR_F;
                        n_phase = PH_VEL1;
                    end
                    scfp_pkg::CH_B: begin
                        n_kind  = scfp_pkg::KIND_MOVE;
                        n_dir   = scfp_pkg::DIR_B;
                        n_phase = PH_VEL1;
                    end
                    scfp_pkg::CH_R: begin
                        n_kind  = scfp_pkg::KIND_MOVE;
                        n_dir   = scfp_pkg::DIR_R;
                        n_phase = PH_VEL1;
                    end
                    scfp_pkg::CH_L: begin
                        n_kind  = scfp_pkg::KIND_MOVE;
                        n_dir   = scfp_pkg::DIR_L;
                        n_phase = PH_VEL1;
                    end
                    default: err = 1'b1;
                endcase
            end
            PH_VEL1: begin
                if (i_rx_byte == scfp_pkg::CH_ZERO) begin
                    n_speed = 7'd0;
                    n_phase = PH_END;
                end else if (is_digit) begin
                    // tens digit: d*10 = d*8 + d*2
                    n_speed = (digit << 3) + (digit << 1);
                    n_phase = PH_VEL2;
                end else begin
                    err = 1'b1;
                end
            end
            PH_VEL2: begin
                if (is_digit) begin
                    n_speed = r_speed + digit;
                    n_phase = PH_END;
                end else begin
                    err = 1'b1;
                end
            end
            PH_END: begin
                if (i_rx_byte == i_cfg.end_byte) begin
                    done    = 1'b1;
                    n_phase = PH_START;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
                // waiting for start; unused codes behave the same
                if (i_rx_byte == i_cfg.start_byte) begin
                    n_kind  = 1'b0;
                    n_cmd   = 2'd0;
                    n_dir   = 2'd0;
                    n_speed = 7'd0;
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_START;
                end
            end
        endcase

        if (err) begin
            n_phase = PH_START;
        end

        n_res                = '0;
        n_res.frame_done     = done;
        n_res.parse_error    = err;
        if (done) begin
            n_res.frame_kind = n_kind;
            if (n_kind == scfp_pkg::KIND_MOVE) begin
                n_res.move_direction = n_dir;
                n_res.move_speed     = n_speed;
            end else begin
                n_res.command_code   = n_cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_kind      <= 1'b0;
            r_cmd       <= 2'd0;
            r_dir       <= 2'd0;
            r_speed     <= 7'd0;
            r_res_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_cmd       <= n_cmd;
                r_dir       <= n_dir;
                r_speed     <= n_speed;
                r_res_valid <= 1'b1;
                r_res       <= n_res;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== hdl/serial_command_frame_parser_core.sv =====
// ---------------------------------------------------------------------------
// serial_command_frame_parser_core
// Byte-stream parser for start/type/speed/end command frames.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ---------------------------
//  rx        in         i_rx_valid / o_rx_ready    i_rx_byte
//  result    out        o_res_valid / i_res_ready  frame_done, kind, code,
//                                                  direction, speed, error
//  config    in         APB (psel/penable/pready)  start_byte @0, end_byte @4
//
//  One beat per cycle while the sink takes results; each rx beat yields one
//  result beat in the next cycle, out of the single result register.
//  The result register frees in the same cycle it is taken, so rx stays
//  ready back to back as long as the sink keeps i_res_ready high.
//  A stalled result holds and blocks rx until the sink takes it.
//  Synchronous active-low reset: parser waits for a start byte, delimiters
//  return to '$' and '#', no result pending.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_command_frame_parser_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    // received byte stream
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [7:0]                  i_rx_byte,

    // parse results
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic                        o_frame_done,
    output logic                        o_frame_kind,
    output logic [1:0]                  o_command_code,
    output logic [1:0]                  o_move_direction,
    output logic [6:0]                  o_move_speed,
    output logic                        o_parse_error
);

    scfp_pkg::t_cfg    cfg;
    scfp_pkg::t_result res;

    // Delimiter registers; the user must write them only while the parser is idle, the block does not enforce it.
    scfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Phase FSM, held frame fields and the result register.
    scfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_rx_ready  (o_rx_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (res)
    );

    // Unpack the result beat onto the field ports
    assign o_frame_done     = res.frame_done;
    assign o_frame_kind     = res.frame_kind;
    assign o_command_code   = res.command_code;
    assign o_move_direction = res.move_direction;
    assign o_move_speed     = res.move_speed;
    assign o_parse_error    = res.parse_error;

    // A byte can close a frame or break it, never both
    `SCFP_ASSERT(a_done_err_excl, o_res_valid |-> !(o_frame_done && o_parse_error))

    // Non-completing beats carry zeroed frame fields
    `SCFP_ASSERT(a_idle_fields_zero, (o_res_valid && !o_frame_done) |-> ((o_frame_kind == 1'b0) && (o_command_code == 2'd0) && (o_move_direction == 2'd0) && (o_move_speed == 7'd0)))

    // Command frames report no direction or speed
    `SCFP_ASSERT(a_cmd_no_move, (o_res_valid && o_frame_done && !o_frame_kind) |-> ((o_move_direction == 2'd0) && (o_move_speed == 7'd0)))

    // A stalled result must back-pressure the rx side
    `SCFP_ASSERT(a_stall_blocks_rx, (o_res_valid && !i_res_ready) |-> !o_rx_ready)

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_command_frame_parser_core.
// Feeds byte streams (clean frames, broken frames, stray bytes) under several
// start/end delimiter settings with random idling on both channels. Each
// accepted rx beat is run through a local frame parser model. Each result
// beat is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 60;    // sink hold-off for the backpressure test
    localparam int unsigned PHASE_BYTES = 150;   // random bytes per delimiter setting

    typedef logic [7:0] t_byte_q[$];

    // parser phase, as the model tracks it
    typedef enum logic [2:0] {
        SEEK_START,
        WANT_TYPE,
        WANT_TENS,
        WANT_UNITS,
        WANT_END
    } t_parse_phase;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [scfp_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        i_rx_valid;
    logic                        o_rx_ready;
    logic [7:0]                  i_rx_byte;
    logic                        o_res_valid;
    logic                        i_res_ready;
    logic                        o_frame_done;
    logic                        o_frame_kind;
    logic [1:0]                  o_command_code;
    logic [1:0]                  o_move_direction;
    logic [6:0]                  o_move_speed;
    logic                        o_parse_error;

    serial_command_frame_parser_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_frame_done     (o_frame_done),
        .o_frame_kind     (o_frame_kind),
        .o_command_code   (o_command_code),
        .o_move_direction (o_move_direction),
        .o_move_speed     (o_move_speed),
        .o_parse_error    (o_parse_error)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model state: delimiters, parse phase and the fields held for the frame
    // ------------------------------------------------------------------------
    logic [7:0]   cfg_start = scfp_pkg::START_BYTE_RST;
    logic [7:0]   cfg_end   = scfp_pkg::END_BYTE_RST;
    t_parse_phase rx_phase  = SEEK_START;
    logic         held_kind  = 1'b0;
    logic [1:0]   held_cmd   = '0;
    logic [1:0]   held_dir   = '0;
    logic [6:0]   held_speed = '0;

    scfp_pkg::t_result pending_results[$];   // predicted, oldest first
    int unsigned n_bytes_sent   = 0;
    int unsigned n_results_seen = 0;
    int unsigned n_frames       = 0;
    int unsigned n_breaks       = 0;
    int unsigned n_settings     = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    // idle knobs, percent chance per beat of starting an idle gap
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned holds_requested = 0;

    // Advance the parser by one byte and return the result beat it causes.
    function automatic scfp_pkg::t_result parse_byte(input logic [7:0] b);
        scfp_pkg::t_result r;
        logic              broke;
        r     = '0;
        broke = 1'b0;
        case (rx_phase)
            WANT_TYPE: begin
                if (b == scfp_pkg::CH_M || b == scfp_pkg::CH_C || b == scfp_pkg::CH_T) begin
                    held_kind = scfp_pkg::KIND_CMD;
                    held_cmd  = (b == scfp_pkg::CH_M) ? scfp_pkg::CMD_M :
                                (b == scfp_pkg::CH_C) ? scfp_pkg::CMD_C : scfp_pkg::CMD_T;
                    rx_phase  = WANT_END;
                end else if (b == scfp_pkg::CH_F || b == scfp_pkg::CH_B ||
                             b == scfp_pkg::CH_R || b == scfp_pkg::CH_L) begin
                    held_kind = scfp_pkg::KIND_MOVE;
                    held_dir  = (b == scfp_pkg::CH_F) ? scfp_pkg::DIR_F :
                                (b == scfp_pkg::CH_B) ? scfp_pkg::DIR_B :
                                (b == scfp_pkg::CH_R) ? scfp_pkg::DIR_R : scfp_pkg::DIR_L;
                    rx_phase  = WANT_TENS;
                end else begin
                    broke = 1'b1;
                end
            end
            WANT_TENS: begin
                // lone '0' is speed zero; otherwise tens digit 1..9
                if (b == scfp_pkg::CH_ZERO) begin
                    held_speed = '0;
                    rx_phase   = WANT_END;
                end else if (b >= scfp_pkg::CH_ONE && b <= scfp_pkg::CH_NINE) begin
                    held_speed = 7'((b - scfp_pkg::CH_ZERO) * 10);
                    rx_phase   = WANT_UNITS;
                end else begin
                    broke = 1'b1;
                end
            end
            WANT_UNITS: begin
                if (b >= scfp_pkg::CH_ZERO && b <= scfp_pkg::CH_NINE) begin
                    held_speed = held_speed + 7'(b - scfp_pkg::CH_ZERO);
                    rx_phase   = WANT_END;
                end else begin
                    broke = 1'b1;
                end
            end
            WANT_END: begin
                if (b == cfg_end) begin
                    r.frame_done = 1'b1;
                    r.frame_kind = held_kind;
                    if (held_kind == scfp_pkg::KIND_MOVE) begin
                        r.move_direction = held_dir;
                        r.move_speed     = held_speed;
                    end else begin
                        r.command_code = held_cmd;
                    end
                    rx_phase = SEEK_START;
                    n_frames++;
                end else begin
                    broke = 1'b1;
                end
            end
            default: begin
                // stray bytes between frames are dropped silently
                if (b == cfg_start) begin
                    held_kind  = 1'b0;
                    held_cmd   = '0;
                    held_dir   = '0;
                    held_speed = '0;
                    rx_phase   = WANT_TYPE;
                end else begin
                    rx_phase = SEEK_START;
                end
            end
        endcase
        // the breaking byte is not re-read as a start byte
        if (broke) begin
            rx_phase = SEEK_START;
            n_breaks++;
        end
        r.parse_error = broke;
        return r;
    endfunction

    // rx monitor: predict on every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_rx_valid && o_rx_ready) begin
            pending_results.push_back(parse_byte(i_rx_byte));
            n_bytes_sent++;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : result_check
        scfp_pkg::t_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            n_results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing predicted");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("frame_done",     want.frame_done,     o_frame_done);
                check_field("frame_kind",     want.frame_kind,     o_frame_kind);
                check_field("command_code",   want.command_code,   o_command_code);
                check_field("move_direction", want.move_direction, o_move_direction);
                check_field("move_speed",     want.move_speed,     o_move_speed);
                check_field("parse_error",    want.parse_error,    o_parse_error);
            end
        end
    end

    // Result sink: random stall bursts, plus a long hold-off on request.
    initial begin : result_sink
        int unsigned stall;
        int unsigned holds_served;
        holds_served = 0;
        i_res_ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != holds_requested) begin
                holds_served++;
                i_res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_res_ready <= 1'b1;
            end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                i_res_ready <= 1'b0;
                stall = $urandom_range(1, 6);
                repeat (stall) @(posedge i_clk);
                i_res_ready <= 1'b1;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("** serial_command_frame_parser_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // rx channel helpers
    // ------------------------------------------------------------------------

    // One rx beat. Valid stays up after acceptance unless the next call idles.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_rx_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
    endtask

    task automatic send_seq(input t_byte_q q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic rx_release();
        i_rx_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] type_char(input int unsigned k);
        case (k)
            0:       return scfp_pkg::CH_M;
            1:       return scfp_pkg::CH_C;
            2:       return scfp_pkg::CH_T;
            3:       return scfp_pkg::CH_F;
            4:       return scfp_pkg::CH_B;
            5:       return scfp_pkg::CH_R;
            default: return scfp_pkg::CH_L;
        endcase
    endfunction

    // Well-formed frame under the current delimiters. Speed applies to moves:
    // 0 gives the lone '0', 10..99 gives two digits.
    function automatic t_byte_q frame_bytes(input logic [7:0] type_ch,
                                            input int unsigned speed);
        t_byte_q q;
        q.push_back(cfg_start);
        q.push_back(type_ch);
        if (type_ch == scfp_pkg::CH_F || type_ch == scfp_pkg::CH_B ||
            type_ch == scfp_pkg::CH_R || type_ch == scfp_pkg::CH_L) begin
            if (speed == 0) begin
                q.push_back(scfp_pkg::CH_ZERO);
            end else begin
                q.push_back(8'(scfp_pkg::CH_ZERO + speed / 10));
                q.push_back(8'(scfp_pkg::CH_ZERO + speed % 10));
            end
        end
        q.push_back(cfg_end);
        return q;
    endfunction

    // Keep the first 'cut' bytes of a frame, then the offending byte.
    function automatic t_byte_q broken_at(input t_byte_q q, input int unsigned cut,
                                          input logic [7:0] bad);
        while (q.size() > cut) void'(q.pop_back());
        q.push_back(bad);
        return q;
    endfunction

    // Mostly clean frames; some broken mid-way, some stray bytes.
    task automatic send_random_frame(input int unsigned broken_pct,
                                     input int unsigned noise_pct);
        t_byte_q     q;
        int unsigned pick;
        int unsigned spd;
        logic [7:0]  bad;
        pick = $urandom_range(0, 99);
        if (pick < noise_pct) begin
            repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
        end else begin
            spd = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 99);
            q   = frame_bytes(type_char($urandom_range(0, 6)), spd);
            if (pick < noise_pct + broken_pct) begin
                // near misses around the digit range and the delimiters
                case ($urandom_range(0, 4))
                    0:       bad = cfg_start;
                    1:       bad = cfg_end;
                    2:       bad = 8'(scfp_pkg::CH_ZERO - 8'd1);
                    3:       bad = 8'(scfp_pkg::CH_NINE + 8'd1);
                    default: bad = 8'($urandom_range(0, 255));
                endcase
                q = broken_at(q, $urandom_range(1, q.size() - 1), bad);
            end
        end
        send_seq(q);
    endtask

    task automatic run_random(input int unsigned n_bytes);
        int unsigned target;
        target = n_bytes_sent + n_bytes;
        while (n_bytes_sent < target) send_random_frame(15, 15);
    endtask

    // ------------------------------------------------------------------------
    // APB helpers
    // ------------------------------------------------------------------------
    task automatic cfg_read(input logic [0:0] idx, input logic [7:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= scfp_pkg::ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field(idx == scfp_pkg::CFG_IDX_START ? "prdata start_byte" : "prdata end_byte",
                    want, prdata[7:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= scfp_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // register takes the value at this edge
        if (idx == scfp_pkg::CFG_IDX_START) cfg_start = value;
        else cfg_end = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        cfg_read(idx, value);
    endtask

    // Only while idle: rx quiet and nothing outstanding.
    task automatic set_delimiters(input logic [7:0] start_b, input logic [7:0] end_b);
        rx_release();
        wait_drain();
        @(posedge i_clk);
        cfg_write(scfp_pkg::CFG_IDX_START, start_b);
        cfg_write(scfp_pkg::CFG_IDX_END, end_b);
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_registers();
        cfg_read(scfp_pkg::CFG_IDX_START, scfp_pkg::START_BYTE_RST);
        cfg_read(scfp_pkg::CFG_IDX_END, scfp_pkg::END_BYTE_RST);
    endtask

    // Byte extremes between frames, then each command and direction once,
    // speeds at zero, the low and the high end.
    task automatic test_every_frame_type();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_seq(frame_bytes(scfp_pkg::CH_M, 0));
        send_seq(frame_bytes(scfp_pkg::CH_C, 0));
        send_seq(frame_bytes(scfp_pkg::CH_T, 0));
        send_seq(frame_bytes(scfp_pkg::CH_F, 0));
        send_seq(frame_bytes(scfp_pkg::CH_B, 10));
        send_seq(frame_bytes(scfp_pkg::CH_R, 99));
        send_seq(frame_bytes(scfp_pkg::CH_L, 57));
    endtask

    task automatic test_broken_frames();
        // second start byte in the type slot breaks the frame and is not a
        // restart, so the rest of the frame is dropped as stray bytes
        send_byte(cfg_start);
        send_seq(frame_bytes(scfp_pkg::CH_M, 0));
        // ':' just past '9' as the units digit
        send_seq(broken_at(frame_bytes(scfp_pkg::CH_F, 57), 3,
                           8'(scfp_pkg::CH_NINE + 8'd1)));
        // start byte where the end byte belongs
        send_seq(broken_at(frame_bytes(scfp_pkg::CH_T, 0), 2, cfg_start));
    endtask

    // Sink stalls for a long stretch while rx keeps offering beats; then
    // the source waits until everything has drained.
    task automatic test_result_backpressure();
        int unsigned target;
        holds_requested++;
        target = n_bytes_sent + 40;
        while (n_bytes_sent < target) send_random_frame(0, 0);
        rx_release();
        wait_drain();
        @(posedge i_clk);
    endtask

    task automatic test_delimiter_settings();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    set_delimiters(scfp_pkg::START_BYTE_RST, scfp_pkg::END_BYTE_RST);
                    src_idle_pct = 20; sink_idle_pct = 20;
                end
                1: begin
                    set_delimiters(8'h00, 8'hFF);
                    src_idle_pct = 0;  sink_idle_pct = 40;
                end
                2: begin
                    set_delimiters(8'hFF, 8'h00);
                    src_idle_pct = 40; sink_idle_pct = 0;
                end
                3: begin
                    // same byte opens a frame, names a command and closes it
                    set_delimiters(scfp_pkg::CH_M, scfp_pkg::CH_M);
                    src_idle_pct = 10; sink_idle_pct = 10;
                end
                default: begin
                    set_delimiters(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    src_idle_pct = 30; sink_idle_pct = 25;
                end
            endcase
            run_random(PHASE_BYTES);
        end
    endtask

    // Back at reset delimiters, full rate on both sides.
    task automatic test_unthrottled_tail();
        set_delimiters(scfp_pkg::START_BYTE_RST, scfp_pkg::END_BYTE_RST);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(PHASE_BYTES);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_rx_valid = 1'b0;
        i_rx_byte  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 20;
        sink_idle_pct = 20;
        test_reset_registers();
        test_every_frame_type();
        test_broken_frames();
        test_result_backpressure();
        test_delimiter_settings();
        test_unthrottled_tail();

        rx_release();
        wait_drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d rx beats and %0d result beats: %0d frames, %0d broken frames",
                 n_bytes_sent, n_results_seen, n_frames, n_breaks);
        $display("over %0d delimiter settings, with random and long result stalls",
                 n_settings + 1);
        if (fail_count == 0) begin
            $display("** serial_command_frame_parser_core: PASSED **");
        end else begin
            $display("** serial_command_frame_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
